>>> design/tld_pkg.sv
// Shared constants, register codes and sequencer states of the touch level detector.
package tld_pkg;

  localparam int CHANNELS    = 3;
  localparam int CAL_SAMPLES = 10;

  localparam int CH_W    = 2;
  localparam int RAW_W   = 24;
  localparam int THR_W   = 10;
  localparam int MD_W    = 24;
  localparam int ALPHA_W = 9;
  localparam int LVL_W   = 18;
  localparam int SUM_W   = 28;
  localparam int MAP_W   = 10;
  localparam int FRAC_W  = 8;
  localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int PROD_W  = MD_W + MAP_W;
  localparam int ACC_W   = LVL_W + ALPHA_W;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [ALPHA_W-1:0] ONE_Q8 = ALPHA_W'(256);

  localparam logic [THR_W-1:0]   THRESHOLD_RST = THR_W'(256);
  localparam logic [MD_W-1:0]    MAX_DIFF_RST  = MD_W'(30000);
  localparam logic [ALPHA_W-1:0] ALPHA_RST     = ALPHA_W'(179);

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = CFG_IDX_W'(2);

  localparam logic OP_CAL  = 1'b0;
  localparam logic OP_MEAS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } tld_state_e;

endpackage

>>> design/touch_level_detector.sv
// Sequence: a measurement request runs 10 divider steps, 9 multiply steps and one commit
// before a change of touch state shows as an event; the next request is taken in the cycle after the commit.
// The commit waits while an earlier event is still held by the output stall.
// A calibration request only adds to its channel sum; the last one of a run also runs 28 divider steps.
// Requests are held off while the shared bit-serial divider and the bit-serial Q1.8 multiplier work.
// Reset is asynchronous, active low: registers return to defaults, all channel state clears.
module touch_level_detector
  import tld_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [CH_W-1:0]       channel_i,
  input  logic [RAW_W-1:0]      raw_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CH_W-1:0]       event_channel_o,
  output logic                  touched_o
);

  tld_state_e state_q, state_d;

  logic [THR_W-1:0]   threshold_q;
  logic [MD_W-1:0]    max_diff_q;
  logic [ALPHA_W-1:0] alpha_q;

  logic [RAW_W-1:0] baseline_q [CHANNELS];
  logic [SUM_W-1:0] cal_sum_q  [CHANNELS];
  logic [CNT_W-1:0] cal_cnt_q  [CHANNELS];
  logic [LVL_W-1:0] level_q    [CHANNELS];
  logic             last_q     [CHANNELS];

  logic              op_q;
  logic [CH_W-1:0]   ch_q;
  logic              tch_q;
  logic [LVL_W-1:0]  lvl_q;
  logic [MD_W-1:0]   rem_q;
  logic [SUM_W-1:0]  sh_q;
  logic [ALPHA_W-1:0] a_sh_q;
  logic [ALPHA_W-1:0] b_sh_q;
  logic [ACC_W-1:0]  acc_q;
  logic [STEP_W-1:0] step_q;

  logic out_valid_q;
  logic [CH_W-1:0] ev_ch_q;
  logic ev_tch_q;

  logic accept, in_range, cal_last, slot_free, last_step;
  logic do_div, do_mul, do_commit;

  logic [RAW_W-1:0]   base_rd;
  logic [RAW_W-1:0]   excess;
  logic [MD_W-1:0]    clamped;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   sum_new;
  logic [CNT_W:0]     cnt_new;
  logic [ALPHA_W-1:0] a_sat;

  logic [MD_W:0]      div_t;
  logic [MD_W:0]      div_dvs;
  logic               div_ge;
  logic [MD_W:0]      div_sub;
  logic [LVL_W-1:0]   m8;
  logic [ACC_W-1:0]   acc_d;
  logic [LVL_W-1:0]   lvl_new;
  logic               now_tch;

  assign in_range  = channel_i < CH_W'(CHANNELS);
  assign accept    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign last_step = step_q == '0;

  // accept-time datapath
  assign base_rd = baseline_q[channel_i];
  assign excess  = (raw_sample_i >= base_rd) ? raw_sample_i - base_rd : '0;
  assign clamped = (excess > max_diff_q) ? max_diff_q : excess;
  assign prod    = {clamped, MAP_W'(0)} - {MAP_W'(0), clamped};
  assign sum_new = cal_sum_q[channel_i] + SUM_W'(raw_sample_i);
  assign cnt_new = {1'b0, cal_cnt_q[channel_i]} + (CNT_W + 1)'(1);
  assign cal_last = cnt_new >= (CNT_W + 1)'(CAL_SAMPLES);
  assign a_sat   = (alpha_q > ONE_Q8) ? ONE_Q8 : alpha_q;

  // shared restoring divider, one quotient bit per cycle
  assign div_t   = {rem_q, sh_q[SUM_W-1]};
  assign div_dvs = (op_q == OP_MEAS) ? {1'b0, max_diff_q} : (MD_W + 1)'(CAL_SAMPLES);
  assign div_ge  = (div_t >= div_dvs) && (div_dvs != '0);
  assign div_sub = div_t - div_dvs;

  // MSB-first shift-add multiply over the bits of alpha and one minus alpha
  assign m8    = {sh_q[MAP_W-1:0], FRAC_W'(0)};
  assign acc_d = {acc_q[ACC_W-2:0], 1'b0}
               + (a_sh_q[ALPHA_W-1] ? ACC_W'(m8) : '0)
               + (b_sh_q[ALPHA_W-1] ? ACC_W'(lvl_q) : '0);

  assign lvl_new = acc_q[LVL_W+FRAC_W-1:FRAC_W];
  assign now_tch = lvl_new[LVL_W-1:FRAC_W] >= threshold_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_range && (op_i == OP_MEAS || cal_last)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step) begin
          state_d = (op_q == OP_MEAS) ? ST_MUL : ST_IDLE;
        end
      end
      ST_MUL: begin
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    do_div     = 1'b0;
    do_mul     = 1'b0;
    do_commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_DIV:  do_div     = 1'b1;
      ST_MUL:  do_mul     = 1'b1;
      ST_DONE: do_commit  = slot_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      threshold_q <= THRESHOLD_RST;
      max_diff_q  <= MAX_DIFF_RST;
      alpha_q     <= ALPHA_RST;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        baseline_q[c] <= '0;
        cal_sum_q[c]  <= '0;
        cal_cnt_q[c]  <= '0;
        level_q[c]    <= '0;
        last_q[c]     <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_THRESHOLD: threshold_q <= cfg_data_i[THR_W-1:0];
          REG_MAX_DIFF:  max_diff_q  <= cfg_data_i[MD_W-1:0];
          REG_ALPHA:     alpha_q     <= cfg_data_i[ALPHA_W-1:0];
          default:       ;
        endcase
      end
      if (accept && in_range && op_i == OP_CAL) begin
        if (cal_last) begin
          cal_sum_q[channel_i] <= '0;
          cal_cnt_q[channel_i] <= '0;
        end else begin
          cal_sum_q[channel_i] <= sum_new;
          cal_cnt_q[channel_i] <= cnt_new[CNT_W-1:0];
        end
      end
      if (do_div && last_step && op_q == OP_CAL) begin
        baseline_q[ch_q] <= {sh_q[RAW_W-2:0], div_ge};
        level_q[ch_q]    <= '0;
      end
      if (do_commit && now_tch != tch_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_commit) begin
        level_q[ch_q] <= lvl_new;
        if (now_tch != tch_q) begin
          last_q[ch_q] <= now_tch;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      ch_q   <= channel_i;
      tch_q  <= last_q[channel_i];
      lvl_q  <= level_q[channel_i];
      a_sh_q <= a_sat;
      b_sh_q <= ONE_Q8 - a_sat;
      acc_q  <= '0;
      if (op_i == OP_MEAS) begin
        rem_q  <= prod[PROD_W-1:MAP_W];
        sh_q   <= {prod[MAP_W-1:0], (SUM_W - MAP_W)'(0)};
        step_q <= STEP_W'(MAP_W - 1);
      end else begin
        rem_q  <= '0;
        sh_q   <= sum_new;
        step_q <= STEP_W'(SUM_W - 1);
      end
    end
    if (do_div) begin
      rem_q  <= div_ge ? div_sub[MD_W-1:0] : div_t[MD_W-1:0];
      sh_q   <= {sh_q[SUM_W-2:0], div_ge};
      step_q <= last_step ? STEP_W'(ALPHA_W - 1) : step_q - STEP_W'(1);
    end
    if (do_mul) begin
      acc_q  <= acc_d;
      a_sh_q <= {a_sh_q[ALPHA_W-2:0], 1'b0};
      b_sh_q <= {b_sh_q[ALPHA_W-2:0], 1'b0};
      step_q <= step_q - STEP_W'(1);
    end
    if (do_commit && now_tch != tch_q) begin
      ev_ch_q  <= ch_q;
      ev_tch_q <= now_tch;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_channel_o = ev_ch_q;
  assign touched_o       = ev_tch_q;

endmodule

>>> design/tld_checker.sv
// Port-level assertions for the touch level detector and their bind.
module tld_checker
  import tld_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  op_i,
  input logic [CH_W-1:0]       channel_i,
  input logic [RAW_W-1:0]      raw_sample_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [CH_W-1:0]       event_channel_o,
  input logic                  touched_o
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_channel_o) && $stable(touched_o))
    else $error("stalled event request changed");

  a_cal_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && op_i == OP_CAL |=> !$rose(out_valid_o))
    else $error("calibration request produced an event");

  a_meas_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && op_i == OP_MEAS && channel_i < CH_W'(CHANNELS) |=> in_stall_o)
    else $error("measurement request did not hold off input");

  a_ev_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_channel_o < CH_W'(CHANNELS))
    else $error("event on nonexistent channel");

endmodule

bind touch_level_detector tld_checker u_tld_checker (.*);
